// File: rtl/core/label_reachability_query_defines.svh
// assertion macros shared by the label reachability query rtl
// no dependencies; included by files that carry concurrent checks
`ifndef LABEL_REACHABILITY_QUERY_DEFINES_SVH
`define LABEL_REACHABILITY_QUERY_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define LRQ_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define LRQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/lrq_pkg.sv
// shared constants, types and command/status structs of the label reachability query
// no dependencies
package lrq_pkg;

   localparam int MAX_VERTICES = 1024;
   // label lists are addressed as {vertex, index}, so this stays a power of two
   localparam int MAX_LABELS   = 64;

   localparam int VERTEX_W    = $clog2(MAX_VERTICES);
   localparam int IDX_W       = $clog2(MAX_LABELS);
   localparam int COUNT_W     = $clog2(MAX_LABELS + 1);
   localparam int VALUE_W     = 10;
   localparam int STORE_DEPTH = MAX_VERTICES * MAX_LABELS;
   localparam int STORE_AW    = VERTEX_W + IDX_W;

   typedef enum logic [1:0] {
      MODE_RECORD = 2'd0,
      MODE_LABEL  = 2'd1,
      MODE_QUERY  = 2'd2
   } lrq_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK
   } lrq_state_type;

   typedef struct packed {
      logic write_record;
      logic write_label;
      logic load_query;
      logic start_walk;
      logic step;
   } lrq_cmd_type;

   typedef struct packed {
      logic pass;
      logic empty;
      logic match;
      logic exhausted;
   } lrq_status_type;

endpackage

// File: rtl/core/label_reachability_query.sv
// top level of the label reachability query: sequencer plus tables and label stores
// depends on lrq_pkg, lrq_ctrl and lrq_datapath
//
// Timing: a request is taken at a rising edge where start is high and busy is low.
// Record writes (mode 0) and label writes (mode 1) complete in that cycle and give
// no result; busy stays low, so another request may follow in the next cycle. Mode 3 is
// taken and ignored. A query (mode 2) raises busy through a record check and, unless the
// components differ, the source level is not below the target level, or either list count
// is zero, a merge walk over the clamped out/in label counts (each up to 64). The walk is
// paced by the label stores: each has one read port with a registered output, and the
// next pair is addressed from the current compare, giving one pair per cycle. The answer
// shows on rsp_reachable for exactly one cycle with rsp_valid, in the cycle in which busy
// falls; a new request may be taken in that same cycle. The receiver cannot stall the
// result, so it must sample it on that cycle. The tables and label stores are not cleared
// by reset: a query must only touch records and label entries (within the stored counts)
// that were written before.

module label_reachability_query (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic [9:0]   req_vertex,
   input  logic [9:0]   req_target_vertex,
   input  logic [9:0]   req_component,
   input  logic [9:0]   req_topo_level,
   input  logic [6:0]   req_out_count,
   input  logic [6:0]   req_in_count,
   input  logic         req_label_side,
   input  logic [5:0]   req_label_index,
   input  logic [9:0]   req_label_value,
   output logic         rsp_valid,
   output logic         rsp_reachable
);

   // command and status between sequencer and datapath
   lrq_pkg::lrq_cmd_type    cmd;
   lrq_pkg::lrq_status_type status;

   // mode decode, check/walk sequencing and the registered result strobe
   lrq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_mode      (req_mode),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_reachable (rsp_reachable)
   );

   // vertex record tables, the two label stores and the walk compare
   lrq_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_vertex        (req_vertex),
      .req_target_vertex (req_target_vertex),
      .req_component     (req_component),
      .req_topo_level    (req_topo_level),
      .req_out_count     (req_out_count),
      .req_in_count      (req_in_count),
      .req_label_side    (req_label_side),
      .req_label_index   (req_label_index),
      .req_label_value   (req_label_value),
      .status            (status)
   );

endmodule

// File: rtl/core/lrq_datapath.sv
// vertex tables, label stores and merge-walk compare of the label reachability query
// depends on lrq_pkg
module lrq_datapath (
   input  logic                           clock,
   input  lrq_pkg::lrq_cmd_type           cmd,
   input  logic [lrq_pkg::VERTEX_W-1:0]   req_vertex,
   input  logic [lrq_pkg::VERTEX_W-1:0]   req_target_vertex,
   input  logic [9:0]                     req_component,
   input  logic [9:0]                     req_topo_level,
   input  logic [lrq_pkg::COUNT_W-1:0]    req_out_count,
   input  logic [lrq_pkg::COUNT_W-1:0]    req_in_count,
   input  logic                           req_label_side,
   input  logic [lrq_pkg::IDX_W-1:0]      req_label_index,
   input  logic [lrq_pkg::VALUE_W-1:0]    req_label_value,
   output lrq_pkg::lrq_status_type        status
);

   function automatic logic [lrq_pkg::COUNT_W-1:0] clamp_count(
      input logic [lrq_pkg::COUNT_W-1:0] c
   );
      logic [lrq_pkg::COUNT_W-1:0] lim;
      lim = lrq_pkg::COUNT_W'(lrq_pkg::MAX_LABELS);
      return (c > lim) ? lim : c;
   endfunction

   // vertex record tables
   logic [9:0]                    component_mem [lrq_pkg::MAX_VERTICES];
   logic [9:0]                    level_mem     [lrq_pkg::MAX_VERTICES];
   logic [lrq_pkg::COUNT_W-1:0]   out_cnt_mem   [lrq_pkg::MAX_VERTICES];
   logic [lrq_pkg::COUNT_W-1:0]   in_cnt_mem    [lrq_pkg::MAX_VERTICES];

   // label stores, entry (v, i) at {v, i}
   logic [lrq_pkg::VALUE_W-1:0]   out_label_mem [lrq_pkg::STORE_DEPTH];
   logic [lrq_pkg::VALUE_W-1:0]   in_label_mem  [lrq_pkg::STORE_DEPTH];

   logic [lrq_pkg::VERTEX_W-1:0]  src_ff;
   logic [lrq_pkg::VERTEX_W-1:0]  dst_ff;
   logic [9:0]                    comp_src_ff;
   logic [9:0]                    comp_dst_ff;
   logic [9:0]                    level_src_ff;
   logic [9:0]                    level_dst_ff;
   logic [lrq_pkg::COUNT_W-1:0]   out_cnt_ff;
   logic [lrq_pkg::COUNT_W-1:0]   in_cnt_ff;
   logic [lrq_pkg::COUNT_W-1:0]   n1_ff;
   logic [lrq_pkg::COUNT_W-1:0]   n2_ff;
   logic [lrq_pkg::COUNT_W-1:0]   i_ff;
   logic [lrq_pkg::COUNT_W-1:0]   j_ff;
   logic [lrq_pkg::COUNT_W-1:0]   i_in;
   logic [lrq_pkg::COUNT_W-1:0]   j_in;
   logic [lrq_pkg::VALUE_W-1:0]   a_ff;
   logic [lrq_pkg::VALUE_W-1:0]   b_ff;

   logic                          a_less;
   logic                          a_greater;
   logic                          label_idx_ok;
   logic                          label_rd;
   logic [lrq_pkg::STORE_AW-1:0]  out_wr_addr;
   logic [lrq_pkg::STORE_AW-1:0]  out_rd_addr;
   logic [lrq_pkg::STORE_AW-1:0]  in_rd_addr;

   assign a_less    = a_ff < b_ff;
   assign a_greater = a_ff > b_ff;
   assign i_in      = a_less    ? i_ff + lrq_pkg::COUNT_W'(1) : i_ff;
   assign j_in      = a_greater ? j_ff + lrq_pkg::COUNT_W'(1) : j_ff;

   assign label_idx_ok = {1'b0, req_label_index} < lrq_pkg::COUNT_W'(lrq_pkg::MAX_LABELS);
   assign label_rd     = cmd.start_walk || cmd.step;
   assign out_wr_addr  = {req_vertex, req_label_index};

   // the next pair is fetched from the compare result, one step per cycle
   assign out_rd_addr = cmd.start_walk ? {src_ff, {lrq_pkg::IDX_W{1'b0}}}
                                       : {src_ff, i_in[lrq_pkg::IDX_W-1:0]};
   assign in_rd_addr  = cmd.start_walk ? {dst_ff, {lrq_pkg::IDX_W{1'b0}}}
                                       : {dst_ff, j_in[lrq_pkg::IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.write_record) begin
         component_mem[req_vertex] <= req_component;
         level_mem[req_vertex]     <= req_topo_level;
         out_cnt_mem[req_vertex]   <= req_out_count;
         in_cnt_mem[req_vertex]    <= req_in_count;
      end
      if (cmd.load_query) begin
         src_ff       <= req_vertex;
         dst_ff       <= req_target_vertex;
         comp_src_ff  <= component_mem[req_vertex];
         comp_dst_ff  <= component_mem[req_target_vertex];
         level_src_ff <= level_mem[req_vertex];
         level_dst_ff <= level_mem[req_target_vertex];
         out_cnt_ff   <= out_cnt_mem[req_vertex];
         in_cnt_ff    <= in_cnt_mem[req_target_vertex];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_label && label_idx_ok && !req_label_side) begin
         out_label_mem[out_wr_addr] <= req_label_value;
      end
      if (label_rd) begin
         a_ff <= out_label_mem[out_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_label && label_idx_ok && req_label_side) begin
         in_label_mem[out_wr_addr] <= req_label_value;
      end
      if (label_rd) begin
         b_ff <= in_label_mem[in_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_walk) begin
         i_ff  <= '0;
         j_ff  <= '0;
         n1_ff <= clamp_count(out_cnt_ff);
         n2_ff <= clamp_count(in_cnt_ff);
      end else if (cmd.step) begin
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   always_comb begin
      status.pass      = (comp_src_ff == comp_dst_ff) && (level_src_ff < level_dst_ff);
      status.empty     = (out_cnt_ff == '0) || (in_cnt_ff == '0);
      status.match     = (a_ff == b_ff);
      status.exhausted = (i_in >= n1_ff) || (j_in >= n2_ff);
   end

endmodule

// File: rtl/core/lrq_ctrl.sv
// query sequencer of the label reachability query: mode decode, walk control, result strobe
// depends on lrq_pkg and label_reachability_query_defines.svh
`include "label_reachability_query_defines.svh"

module lrq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               req_mode,
   input  lrq_pkg::lrq_status_type  status,
   output lrq_pkg::lrq_cmd_type     cmd,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic                     rsp_reachable
);

   lrq_pkg::lrq_state_type state_ff;
   lrq_pkg::lrq_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_reachable_ff;
   logic                   rsp_reachable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reachable_ff <= rsp_reachable_in;
   end

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      rsp_valid_in     = 1'b0;
      rsp_reachable_in = 1'b0;
      unique case (state_ff)
         lrq_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  lrq_pkg::MODE_RECORD: begin
                     cmd.write_record = 1'b1;
                  end
                  lrq_pkg::MODE_LABEL: begin
                     cmd.write_label = 1'b1;
                  end
                  lrq_pkg::MODE_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = lrq_pkg::ST_CHECK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lrq_pkg::ST_CHECK: begin
            if (!status.pass || status.empty) begin
               rsp_valid_in = 1'b1;
               state_in     = lrq_pkg::ST_IDLE;
            end else begin
               cmd.start_walk = 1'b1;
               state_in       = lrq_pkg::ST_WALK;
            end
         end
         lrq_pkg::ST_WALK: begin
            priority if (status.match) begin
               rsp_valid_in     = 1'b1;
               rsp_reachable_in = 1'b1;
               state_in         = lrq_pkg::ST_IDLE;
            end else if (status.exhausted) begin
               rsp_valid_in = 1'b1;
               state_in     = lrq_pkg::ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = lrq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != lrq_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;

   `LRQ_ASSERT_NEXT(a_query_goes_busy, clock, reset, start && !busy && req_mode == lrq_pkg::MODE_QUERY, busy, "accepted query did not make the block busy")
   `LRQ_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held for two cycles")
   `LRQ_ASSERT_SAME(a_hit_from_match, clock, reset, rsp_valid_ff && rsp_reachable_ff, $past(status.match) && $past(state_ff) == lrq_pkg::ST_WALK, "reachable answer without a label match")
   `LRQ_ASSERT_SAME(a_check_after_load, clock, reset, state_ff == lrq_pkg::ST_CHECK, $past(cmd.load_query), "record check entered without a query load")

endmodule
